// ===== rtl/assert_macros.svh =====
// Assertion macros used by the divider RTL.
// Depends on nothing; files that check properties include it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_STD(lbl, prop, msg) `ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_STD(lbl, prop, msg)
`endif
`endif

// ===== rtl/dld_pkg.sv =====
// Types and constants of the decimal long divider.
// Used by the front, the command queue, the back and the top level.
package dld_pkg;

  localparam int unsigned DIGIT_W   = 4;
  localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN = 4'd10;

  localparam logic ACT_LOAD     = 1'b0;
  localparam logic ACT_DIVIDEND = 1'b1;

  localparam logic KIND_QUO = 1'b0;
  localparam logic KIND_REM = 1'b1;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_ZERO = 2'd1,
    ERR_LONG = 2'd2
  } err_e;

  typedef enum logic [1:0] {
    OP_DVS = 2'd0,
    OP_DIV = 2'd1,
    OP_ERR = 2'd2
  } op_e;

  typedef struct packed {
    op_e               op;
    logic              fresh;
    logic              store;
    logic [DIGIT_W-1:0] digit;
    logic              last;
    err_e              err;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUB,
    ST_QOUT,
    ST_REM,
    ST_ERR
  } back_state_e;

endpackage

// ===== rtl/dld_intf.sv =====
// Channel interfaces of the decimal long divider: input digits and result digits.
// Depends on nothing.
interface dld_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [3:0] digit;
  logic       last;

  modport source (output valid, action, digit, last, input ready);
  modport sink (input valid, action, digit, last, output ready);
endinterface

interface dld_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [3:0] out_digit;
  logic       final_res;
  logic [1:0] error;

  modport source (output valid, kind, out_digit, final_res, error, input ready);
  modport sink (input valid, kind, out_digit, final_res, error, output ready);
endinterface

// ===== rtl/dld_front.sv =====
// Front of the divider: takes input transfers, tracks the divisor load and
// turns each digit into a command. Depends on dld_pkg and dld_in_if.
module dld_front import dld_pkg::*; #(
  parameter int unsigned MAX_DIVISOR_DIGITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dld_in_if.sink     in_i,
  input  logic       full_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  localparam int unsigned LenW = $clog2(MAX_DIVISOR_DIGITS + 1);

  logic            load_open_q, load_open_d;
  logic [LenW-1:0] len_q, len_d, len_eff;
  logic            too_long_q, too_long_d, too_eff;
  logic [DIGIT_W-1:0] digit_c;
  logic            fresh, significant, store, accept;

  assign in_i.ready = !full_i;

  always_comb begin
    digit_c     = (in_i.digit > DIGIT_MAX) ? DIGIT_MAX : in_i.digit;
    accept      = in_i.valid && in_i.ready;
    fresh       = (in_i.action == ACT_LOAD) && !load_open_q;
    len_eff     = fresh ? '0 : len_q;
    too_eff     = fresh ? 1'b0 : too_long_q;
    significant = (digit_c != '0) || (len_eff != '0);
    store       = significant && (len_eff < LenW'(MAX_DIVISOR_DIGITS));

    load_open_d = load_open_q;
    len_d       = len_q;
    too_long_d  = too_long_q;
    push_o      = 1'b0;
    cmd_o.op    = OP_DVS;
    cmd_o.fresh = fresh;
    cmd_o.store = store;
    cmd_o.digit = digit_c;
    cmd_o.last  = in_i.last;
    cmd_o.err   = too_long_q ? ERR_LONG : ERR_ZERO;

    if (accept) begin
      if (in_i.action == ACT_LOAD) begin
        push_o      = fresh || store;
        len_d       = len_eff + LenW'(store);
        too_long_d  = too_eff || (significant && !store);
        load_open_d = !in_i.last;
      end else begin
        load_open_d = 1'b0;
        if (too_long_q || (len_q == '0)) begin
          cmd_o.op = OP_ERR;
          push_o   = in_i.last;
        end else begin
          cmd_o.op = OP_DIV;
          push_o   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_open_q <= 1'b0;
      len_q       <= '0;
      too_long_q  <= 1'b0;
    end else begin
      load_open_q <= load_open_d;
      len_q       <= len_d;
      too_long_q  <= too_long_d;
    end
  end

endmodule

// ===== rtl/dld_queue.sv =====
// Two-entry command queue between the front and the back of the divider.
// Depends on dld_pkg for the command type.
module dld_queue import dld_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  output logic valid_o,
  output cmd_t cmd_o,
  input  logic pop_i
);

  cmd_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_q + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

// ===== rtl/dld_back.sv =====
// Back of the divider: holds divisor and remainder, runs the subtract loop and
// drives the result register. Depends on dld_pkg, dld_out_if, assert_macros.svh.
`include "assert_macros.svh"
module dld_back import dld_pkg::*; #(
  parameter int unsigned MAX_DIVISOR_DIGITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cmd_valid_i,
  input  cmd_t       cmd_i,
  output logic       pop_o,
  dld_out_if.source  out_o
);

  localparam int unsigned RemDigits = MAX_DIVISOR_DIGITS + 1;
  localparam int unsigned CntW      = $clog2(RemDigits);

  back_state_e state_q, state_d;
  logic [MAX_DIVISOR_DIGITS-1:0][DIGIT_W-1:0] dvs_q, dvs_d, dvs_base;
  logic [RemDigits-1:0][DIGIT_W-1:0] rem_q, rem_d, dvs_ext, diff;
  logic [RemDigits-1:0] gen, prp, bin;
  logic [RemDigits:0]   sum;
  logic                 rem_ge;
  logic [DIGIT_W:0]     t;
  logic [DIGIT_W-1:0]   k_q, k_d, top;
  logic                 last_q, last_d, seen_q, seen_d, started_q, started_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  err_e                 err_q, err_d;

  logic                 slot_free, emit, emit_kind, emit_fin;
  logic [DIGIT_W-1:0]   emit_digit;
  err_e                 emit_err;
  logic                 out_valid_q, out_kind_q, out_fin_q;
  logic [DIGIT_W-1:0]   out_digit_q;
  err_e                 out_err_q;

  // Borrows of the digit-wise subtraction come from one binary add of the
  // per-digit less-than and equal flags.
  always_comb begin
    dvs_ext = {{DIGIT_W{1'b0}}, dvs_q};
    for (int i = 0; i < RemDigits; i++) begin
      gen[i] = rem_q[i] < dvs_ext[i];
      prp[i] = rem_q[i] == dvs_ext[i];
    end
    sum    = {1'b0, gen | prp} + {1'b0, gen};
    bin    = sum[RemDigits-1:0] ^ prp;
    rem_ge = !sum[RemDigits];
    for (int i = 0; i < RemDigits; i++) begin
      t       = {1'b0, rem_q[i]} - {1'b0, dvs_ext[i]} - (DIGIT_W + 1)'(bin[i]);
      diff[i] = t[DIGIT_W] ? (t[DIGIT_W-1:0] + DIGIT_TEN) : t[DIGIT_W-1:0];
    end
  end

  assign slot_free = !out_valid_q || out_o.ready;
  assign top       = rem_q[RemDigits-1];

  always_comb begin
    state_d    = state_q;
    dvs_d      = dvs_q;
    rem_d      = rem_q;
    k_d        = k_q;
    last_d     = last_q;
    seen_d     = seen_q;
    started_d  = started_q;
    cnt_d      = cnt_q;
    err_d      = err_q;
    pop_o      = 1'b0;
    emit       = 1'b0;
    emit_kind  = KIND_QUO;
    emit_digit = k_q;
    emit_fin   = 1'b0;
    emit_err   = ERR_NONE;
    dvs_base   = cmd_i.fresh ? '0 : dvs_q;

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          pop_o = 1'b1;
          unique case (cmd_i.op)
            OP_DVS: begin
              if (cmd_i.fresh) begin
                dvs_d  = '0;
                rem_d  = '0;
                seen_d = 1'b0;
              end
              if (cmd_i.store) begin
                dvs_d[0] = cmd_i.digit;
                for (int i = 1; i < MAX_DIVISOR_DIGITS; i++) begin
                  dvs_d[i] = dvs_base[i-1];
                end
              end
            end
            OP_DIV: begin
              rem_d   = {rem_q[RemDigits-2:0], cmd_i.digit};
              k_d     = '0;
              last_d  = cmd_i.last;
              state_d = ST_SUB;
            end
            OP_ERR: begin
              err_d   = cmd_i.err;
              state_d = ST_ERR;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SUB: begin
        if (rem_ge) begin
          rem_d = diff;
          k_d   = k_q + 1'b1;
        end else if ((k_q != '0) || seen_q || last_q) begin
          state_d = ST_QOUT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_QOUT: begin
        if (slot_free) begin
          emit   = 1'b1;
          seen_d = 1'b1;
          if (last_q) begin
            cnt_d     = CntW'(RemDigits - 1);
            started_d = 1'b0;
            state_d   = ST_REM;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_REM: begin
        emit_kind  = KIND_REM;
        emit_digit = top;
        emit_fin   = (cnt_q == '0);
        if (!started_q && (top == '0) && (cnt_q != '0)) begin
          rem_d = {rem_q[RemDigits-2:0], {DIGIT_W{1'b0}}};
          cnt_d = cnt_q - 1'b1;
        end else if (slot_free) begin
          emit      = 1'b1;
          started_d = 1'b1;
          rem_d     = {rem_q[RemDigits-2:0], {DIGIT_W{1'b0}}};
          if (cnt_q == '0) begin
            seen_d  = 1'b0;
            state_d = ST_IDLE;
          end else begin
            cnt_d = cnt_q - 1'b1;
          end
        end
      end
      ST_ERR: begin
        emit_digit = '0;
        emit_fin   = 1'b1;
        emit_err   = err_q;
        if (slot_free) begin
          emit    = 1'b1;
          rem_d   = '0;
          seen_d  = 1'b0;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      dvs_q       <= '0;
      rem_q       <= '0;
      seen_q      <= 1'b0;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      dvs_q     <= dvs_d;
      rem_q     <= rem_d;
      seen_q    <= seen_d;
      started_q <= started_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    last_q <= last_d;
    cnt_q  <= cnt_d;
    err_q  <= err_d;
    if (emit) begin
      out_kind_q  <= emit_kind;
      out_digit_q <= emit_digit;
      out_fin_q   <= emit_fin;
      out_err_q   <= emit_err;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.kind      = out_kind_q;
  assign out_o.out_digit = out_digit_q;
  assign out_o.final_res = out_fin_q;
  assign out_o.error     = out_err_q;

  `ASSERT_STD(a_quo_digit_range, (state_q == ST_SUB) |-> (k_q <= DIGIT_MAX), "quotient above nine")
  `ASSERT_STD(a_err_rem_clear, (state_q == ST_ERR) |-> (rem_q == '0), "remainder not clear")
  `ASSERT_STD(a_rem_after_quo, (state_q == ST_REM) |-> seen_q, "remainder before quotient")
  `ASSERT_STD(a_rem_no_err, (emit_kind == KIND_REM) |-> (emit_err == ERR_NONE), "error on remainder")

endmodule

// ===== rtl/decimal_long_divider.sv =====
// Top level of the decimal long divider: front, command queue and back.
// Depends on dld_pkg, dld_intf, dld_front, dld_queue and dld_back.
//
//   Port    Dir  Carries
//   in_i    in   action, digit, last: one divisor or dividend digit per transfer
//   out_o   out  kind, out_digit, final_res, error: one result digit per transfer
//
// Divisor digits go into the back in its idle state. A dividend digit is shifted into
// the remainder and the divisor subtracted while it fits; the quotient digit (0 to 9)
// is sent but for leading zeros. The last dividend digit then sends the remainder,
// MAX_DIVISOR_DIGITS + 1 digits less leading zeros. The back ends a digit before taking
// the next, with a two-entry queue in front. Reset clears control state but k, last, cnt
// and err; the block is ready as it ends. A stalled result holds the back at a send.
module decimal_long_divider import dld_pkg::*; #(
  parameter int unsigned MAX_DIVISOR_DIGITS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dld_in_if.sink    in_i,
  dld_out_if.source out_o
);

  logic push, full, cmd_valid, pop;
  cmd_t cmd_in, cmd_out;

  dld_front #(
    .MAX_DIVISOR_DIGITS(MAX_DIVISOR_DIGITS)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .cmd_o  (cmd_in)
  );

  dld_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .full_o  (full),
    .valid_o (cmd_valid),
    .cmd_o   (cmd_out),
    .pop_i   (pop)
  );

  dld_back #(
    .MAX_DIVISOR_DIGITS(MAX_DIVISOR_DIGITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_out),
    .pop_o       (pop),
    .out_o       (out_o)
  );

endmodule
